[design/apd_pkg.sv]
// Shared types, constants and register codes for the adaptive playout delay block.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package apd_pkg;

    // Tuning constants
    localparam int FRAME_SIZE          = 160;
    localparam int VARIANCE_SHIFT      = 5;
    localparam int VARIANCE_GAIN_SHIFT = 2;
    localparam int PLAYOUT_SHIFT       = 5;
    localparam int INITIAL_DELAY       = 1280;

    // Accumulator to delay scaling: right shift normally, left shift when the
    // gain shift exceeds the variance shift.
    localparam int VAR_DN = (VARIANCE_SHIFT >= VARIANCE_GAIN_SHIFT) ?
                            (VARIANCE_SHIFT - VARIANCE_GAIN_SHIFT) : 0;
    localparam int VAR_UP = (VARIANCE_SHIFT >= VARIANCE_GAIN_SHIFT) ?
                            0 : (VARIANCE_GAIN_SHIFT - VARIANCE_SHIFT);

    localparam logic signed [31:0] FRAME_1 = 32'(FRAME_SIZE);
    localparam logic signed [31:0] FRAME_3 = 32'(3 * FRAME_SIZE);
    localparam logic signed [31:0] FRAME_4 = 32'(4 * FRAME_SIZE);
    localparam logic signed [31:0] FRAME_5 = 32'(5 * FRAME_SIZE);
    localparam logic signed [31:0] FRAME_10 = 32'(10 * FRAME_SIZE);

    localparam logic [31:0] VAR_ACC_RST  = (32'(INITIAL_DELAY) << VAR_DN) >> VAR_UP;
    localparam logic [31:0] PLAY_ACC_RST = 32'(INITIAL_DELAY) << PLAYOUT_SHIFT;

    // Configuration registers
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LECTURE_MODE = 2'd2;

    localparam logic [19:0] MAX_DELAY_RST = 20'd48000;
    localparam logic [15:0] MIN_DELAY_RST = 16'd160;

    typedef struct packed {
        logic [19:0] max_delay;
        logic [15:0] min_delay;
        logic        lecture_mode;
    } t_cfg;

    typedef struct packed {
        logic [31:0] media_timestamp;
        logic [31:0] arrival_clock;
        logic        spurt_start;
    } t_item;

    typedef struct packed {
        logic [31:0] host_offset;
        logic [31:0] variance_acc;
        logic [31:0] playout_acc;
        logic [31:0] predicted_drop_stamp;
        logic [31:0] last_relative_arrival;
        logic [31:0] late_count;
    } t_state;

    typedef struct packed {
        logic [19:0]        playout_offset;
        logic               late;
        logic signed [31:0] jitter_estimate;
        logic [31:0]        late_total;
    } t_result;

endpackage

[design/apd_newoff.sv]
// Playout offset recomputation: clamp, step limit and final range clamp.
// Depends on apd_pkg.
`timescale 1ns / 1ps

module apd_newoff (
    input  apd_pkg::t_cfg      i_cfg,
    input  logic signed [31:0] i_nvar,
    input  logic signed [31:0] i_play,
    output logic signed [31:0] o_offset
);

    logic signed [31:0] maxd;
    logic signed [31:0] mind;
    logic [21:0]        max_x3;
    logic [22:0]        max_x7;
    logic signed [31:0] max_34;
    logic signed [31:0] max_78;
    logic signed [31:0] clamped;
    logic signed [31:0] diff;
    logic signed [31:0] neg_diff;
    logic signed [31:0] step;
    logic signed [31:0] cand;

    assign maxd   = $signed({12'd0, i_cfg.max_delay});
    assign mind   = $signed({16'd0, i_cfg.min_delay});
    assign max_x3 = {2'd0, i_cfg.max_delay} + {1'b0, i_cfg.max_delay, 1'b0};
    assign max_x7 = {i_cfg.max_delay, 3'd0} - {3'd0, i_cfg.max_delay};
    assign max_34 = $signed({12'd0, max_x3[21:2]});
    assign max_78 = $signed({12'd0, max_x7[22:3]});

    always_comb begin
        clamped  = (i_nvar > maxd) ? maxd : i_nvar;
        diff     = i_play - clamped;
        neg_diff = -diff;
        step     = diff;
        cand     = clamped;
        if (diff > 0) begin
            if (i_cfg.lecture_mode) begin
                if (diff > apd_pkg::FRAME_1) begin
                    if (i_play > max_34 && diff > apd_pkg::FRAME_10) begin
                        step = apd_pkg::FRAME_5;
                    end else begin
                        step = apd_pkg::FRAME_1;
                    end
                end
            end else begin
                step = diff >>> 1;
            end
            cand = i_play - step;
        end else if (neg_diff > maxd) begin
            cand = max_34;
        end
        if (cand > max_78) begin
            o_offset = max_78;
        end else if (cand < mind) begin
            o_offset = mind;
        end else begin
            o_offset = cand;
        end
    end

endmodule

[design/apd_step.sv]
// Per-packet update: offset decision, jitter filter, playout smoothing, late count.
// Depends on apd_pkg and apd_newoff.
`timescale 1ns / 1ps

module apd_step (
    input  apd_pkg::t_cfg    i_cfg,
    input  apd_pkg::t_item   i_item,
    input  apd_pkg::t_state  i_state,
    output apd_pkg::t_state  o_state,
    output apd_pkg::t_result o_result
);

    logic [31:0]        ts;
    logic [31:0]        now;
    logic [31:0]        rel;
    logic signed [31:0] var_s;
    logic signed [31:0] nvar;
    logic signed [31:0] play;
    logic signed [31:0] maxd;
    logic signed [31:0] mind;
    logic signed [31:0] off_raw;
    logic signed [31:0] play_gap;
    logic signed [31:0] play_gap_abs;
    logic signed [31:0] new_off;
    logic signed [31:0] spurt_off;
    logic signed [31:0] spurt_cl;
    logic signed [31:0] first_off;
    logic signed [31:0] arr_gap;
    logic signed [31:0] arr_gap_abs;
    logic signed [31:0] var_dev;
    logic signed [31:0] off;
    logic               first;
    logic               recalc;
    logic               out_of_range;
    logic               resync;
    logic               late;
    logic [31:0]        var_next;

    assign ts    = i_item.media_timestamp;
    assign now   = i_item.arrival_clock;
    assign rel   = ts - now;
    assign var_s = $signed(i_state.variance_acc);
    assign nvar  = (var_s >>> apd_pkg::VAR_DN) <<< apd_pkg::VAR_UP;
    assign play  = $signed(i_state.playout_acc >> apd_pkg::PLAYOUT_SHIFT);
    assign maxd  = $signed({12'd0, i_cfg.max_delay});
    assign mind  = $signed({16'd0, i_cfg.min_delay});

    assign off_raw = $signed((ts + i_state.host_offset - now) & ~32'd3);

    apd_newoff u_newoff (
        .i_cfg   (i_cfg),
        .i_nvar  (nvar),
        .i_play  (play),
        .o_offset(new_off)
    );

    always_comb begin
        first        = (i_state.host_offset == 32'd0) || i_item.spurt_start;
        play_gap     = play - nvar;
        play_gap_abs = play_gap[31] ? -play_gap : play_gap;
        recalc       = (nvar < apd_pkg::FRAME_3) || (play_gap_abs >= apd_pkg::FRAME_1);
        spurt_off    = new_off - apd_pkg::FRAME_4;
        spurt_cl     = (spurt_off < mind) ? mind : spurt_off;
        if (recalc) begin
            first_off = i_item.spurt_start ? spurt_cl : new_off;
        end else begin
            first_off = play;
        end

        out_of_range = off_raw[31] || (off_raw > maxd);
        resync       = off_raw[31] || (i_state.predicted_drop_stamp == ts);

        // Jitter filter on the change in relative transit time
        arr_gap     = $signed(rel - i_state.last_relative_arrival);
        arr_gap_abs = arr_gap[31] ? -arr_gap : arr_gap;
        var_dev     = arr_gap_abs - (var_s >>> apd_pkg::VARIANCE_SHIFT);

        o_state  = i_state;
        late     = 1'b0;
        var_next = i_state.variance_acc;
        off      = off_raw;

        if (first) begin
            off = first_off;
            o_state.host_offset = now - ts + off;
        end else if (out_of_range) begin
            if (resync) begin
                off = new_off;
                o_state.host_offset = now - ts + off;
            end else begin
                late = 1'b1;
            end
        end else begin
            var_next = i_state.variance_acc + var_dev;
        end

        o_state.variance_acc          = var_next;
        o_state.last_relative_arrival = rel;
        if (late) begin
            o_state.predicted_drop_stamp = ts + {16'd0, i_cfg.min_delay};
            o_state.late_count           = i_state.late_count + 32'd1;
        end else begin
            o_state.playout_acc = i_state.playout_acc
                                + (off - (i_state.playout_acc >> apd_pkg::PLAYOUT_SHIFT));
        end

        o_result.playout_offset  = late ? 20'd0 : {off[19:2], 2'b00};
        o_result.late            = late;
        o_result.jitter_estimate = $signed(var_next) >>> apd_pkg::VARIANCE_SHIFT;
        o_result.late_total      = o_state.late_count;
    end

endmodule

[design/adaptive_playout_delay_top.sv]
// Adaptive playout delay estimator: top level with handshake, state and config.
// A packet is captured in the input register, then its result loads into the result register on advance.
// Throughput: one packet per cycle while the result channel is not stalled, set by the single state update path.
// Reset (i_rst_n low, synchronous): pipeline empty, state and config to defaults.
// Depends on apd_pkg and apd_step.
`timescale 1ns / 1ps

module adaptive_playout_delay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // packet input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_media_timestamp,
    input  logic [31:0] i_arrival_clock,
    input  logic        i_spurt_start,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [19:0] o_playout_offset,
    output logic        o_late,
    output logic signed [31:0] o_jitter_estimate,
    output logic [31:0] o_late_total,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [apd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    apd_pkg::t_cfg    r_cfg;
    apd_pkg::t_state  r_state;
    apd_pkg::t_state  n_state;
    apd_pkg::t_item   r_item;
    apd_pkg::t_result r_out;
    apd_pkg::t_result n_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;
    logic             in_xfer;

    // Move the held packet on whenever the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_delay    <= apd_pkg::MAX_DELAY_RST;
            r_cfg.min_delay    <= apd_pkg::MIN_DELAY_RST;
            r_cfg.lecture_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                apd_pkg::CFG_MAX_DELAY:    r_cfg.max_delay    <= i_cfg_data;
                apd_pkg::CFG_MIN_DELAY:    r_cfg.min_delay    <= i_cfg_data[15:0];
                apd_pkg::CFG_LECTURE_MODE: r_cfg.lecture_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: hold the packet until it is folded into the state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.media_timestamp <= i_media_timestamp;
            r_item.arrival_clock   <= i_arrival_clock;
            r_item.spurt_start     <= i_spurt_start;
        end
    end

    apd_step u_step (
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_result(n_out)
    );

    // Estimator state: commit exactly once per packet, in step with its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.host_offset           <= '0;
            r_state.variance_acc          <= apd_pkg::VAR_ACC_RST;
            r_state.playout_acc           <= apd_pkg::PLAY_ACC_RST;
            r_state.predicted_drop_stamp  <= '1;
            r_state.last_relative_arrival <= '0;
            r_state.late_count            <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on advance, drop once the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_playout_offset  = r_out.playout_offset;
    assign o_late            = r_out.late;
    assign o_jitter_estimate = r_out.jitter_estimate;
    assign o_late_total      = r_out.late_total;

endmodule
